// ===== design/dsft_pkg.sv =====
// Shared types, codes and constants of the delayed solenoid fire timer.
package dsft_pkg;

  localparam int OP_W   = 3;
  localparam int NOW_W  = 32;
  localparam int DIST_W = 16;
  localparam int HOLD_W = 16;
  localparam int TONE_W = 2;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  // Quotient of a 16-bit delay by ten fits in 13 bits.
  localparam int DLY_Q_W = 13;

  localparam logic [NOW_W-1:0]  RELEASE_GUARD = 32'd100;
  localparam logic [DIST_W-1:0] SENSOR_LIMIT  = 16'd823;
  localparam logic [HOLD_W-1:0] DELAY_RESET   = 16'd1500;
  localparam logic [HOLD_W-1:0] HOLD_RESET    = 16'd300;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x.
  localparam logic [31:0] DIV10_RECIP = 32'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [OP_W-1:0] {
    OP_FH_REQ = 3'd0,
    OP_FH_REL = 3'd1,
    OP_UA_REQ = 3'd2,
    OP_UA_REL = 3'd3,
    OP_SENSE  = 3'd4,
    OP_TICK   = 3'd5
  } op_t;

  typedef enum logic [TONE_W-1:0] {
    TONE_NONE = 2'd0,
    TONE_OK   = 2'd1,
    TONE_FIRE = 2'd2
  } tone_t;

  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_DELAY   = 2'd1,
    REG_FH_HOLD = 2'd2,
    REG_UA_HOLD = 2'd3
  } reg_idx_t;

  // Per-channel command for one item.
  typedef struct packed {
    logic              req;
    logic              rel;
    logic              arm;
    logic              tick;
    logic [NOW_W-1:0]  now;
    logic [NOW_W-1:0]  arm_time;
    logic [HOLD_W-1:0] hold;
  } chan_cmd_t;

  // Per-channel state.
  typedef struct packed {
    logic             pin;
    logic             order;
    logic [NOW_W-1:0] order_time;
  } chan_stat_t;

endpackage

// ===== design/dsft_if.sv =====
// Item channel interfaces: input items and result items.
interface dsft_in_if;
  logic                        valid;
  logic                        ready;
  logic [dsft_pkg::OP_W-1:0]   operation;
  logic [dsft_pkg::NOW_W-1:0]  now_ticks;
  logic [dsft_pkg::DIST_W-1:0] distance_a;
  logic [dsft_pkg::DIST_W-1:0] distance_b;

  modport source (output valid, operation, now_ticks, distance_a, distance_b, input ready);
  modport sink   (input valid, operation, now_ticks, distance_a, distance_b, output ready);
endinterface

interface dsft_out_if;
  logic                        valid;
  logic                        ready;
  logic                        forehand_drive;
  logic                        underarm_drive;
  logic                        forehand_pending;
  logic                        underarm_pending;
  logic [dsft_pkg::NOW_W-1:0]  forehand_when;
  logic [dsft_pkg::NOW_W-1:0]  underarm_when;
  logic [dsft_pkg::TONE_W-1:0] tone;

  modport source (output valid, forehand_drive, underarm_drive, forehand_pending,
                  underarm_pending, forehand_when, underarm_when, tone, input ready);
  modport sink   (input valid, forehand_drive, underarm_drive, forehand_pending,
                  underarm_pending, forehand_when, underarm_when, tone, output ready);
endinterface

// ===== design/delayed_solenoid_fire_timer.sv =====
// Top level of the two-channel delayed solenoid fire timer.
//
//  channel   direction  handshake            payload
//  in_if     in         valid/ready          operation, now_ticks, distance_a, distance_b
//  out_if    out        valid/ready          drives, pendings, whens, tone
//  apb       in         psel/penable/pwrite  paddr[3:0], pwdata, prdata (4 registers)
//
// One item per cycle sustained while the result is taken; each item passes the
// input register and then sits in the result register until out_if takes it.
// The channel state updates as an item leaves the input register, so the next
// item already sees it. A stalled result holds both stages; no item is dropped.
// rst_n is synchronous; it clears channel state and valid flags and loads the config registers.
module delayed_solenoid_fire_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  dsft_in_if.sink                     in_if,
  dsft_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsft_pkg::CFG_AW-1:0] paddr,
  input  logic [dsft_pkg::CFG_DW-1:0] pwdata,
  output logic [dsft_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import dsft_pkg::*;

  // Configuration registers
  logic               enable_r;
  logic [HOLD_W-1:0]  delay_raw_r;
  logic [HOLD_W-1:0]  fh_hold_r;
  logic [HOLD_W-1:0]  ua_hold_r;
  logic [DLY_Q_W-1:0] delay_q_r, delay_q_nxt;
  logic [31:0]        delay_prod;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      delay_raw_r <= DELAY_RESET;
      fh_hold_r   <= HOLD_RESET;
      ua_hold_r   <= HOLD_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:  enable_r    <= pwdata[0];
        REG_DELAY:   delay_raw_r <= pwdata[HOLD_W-1:0];
        REG_FH_HOLD: fh_hold_r   <= pwdata[HOLD_W-1:0];
        REG_UA_HOLD: ua_hold_r   <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:  prdata = CFG_DW'(enable_r);
      REG_DELAY:   prdata = CFG_DW'(delay_raw_r);
      REG_FH_HOLD: prdata = CFG_DW'(fh_hold_r);
      REG_UA_HOLD: prdata = CFG_DW'(ua_hold_r);
      default:     prdata = '0;
    endcase
  end

  // Keep the delay divided by ten in a register; it is registered from delay_raw_r after a write.
  assign delay_prod  = 32'(delay_raw_r) * DIV10_RECIP;
  assign delay_q_nxt = DLY_Q_W'(delay_prod >> DIV10_SHIFT);

  always_ff @(posedge clk) begin
    delay_q_r <= delay_q_nxt;
  end

  // Input register
  logic              in_valid_r;
  logic [OP_W-1:0]   op_r;
  logic [NOW_W-1:0]  now_r;
  logic [DIST_W-1:0] dist_a_r;
  logic [DIST_W-1:0] dist_b_r;
  logic              out_valid_r;
  logic              adv;
  logic              proc;

  assign adv         = !out_valid_r || out_if.ready;
  assign proc        = in_valid_r && adv;
  assign in_if.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      op_r     <= in_if.operation;
      now_r    <= in_if.now_ticks;
      dist_a_r <= in_if.distance_a;
      dist_b_r <= in_if.distance_b;
    end
  end

  // Item decode
  chan_cmd_t  fh_cmd, ua_cmd;
  chan_stat_t fh_stat, ua_stat, fh_nxt, ua_nxt;
  logic       fh_fire, ua_fire;
  logic       a_ok, b_ok, sens_arm;
  tone_t      tone_nxt;

  assign a_ok     = (dist_a_r != '0) && (dist_a_r < SENSOR_LIMIT);
  assign b_ok     = (dist_b_r != '0) && (dist_b_r < SENSOR_LIMIT);
  assign sens_arm = (op_r == OP_SENSE) && (a_ok || b_ok) && enable_r && !fh_stat.order;

  always_comb begin
    fh_cmd          = '0;
    ua_cmd          = '0;
    fh_cmd.now      = now_r;
    ua_cmd.now      = now_r;
    fh_cmd.hold     = fh_hold_r;
    ua_cmd.hold     = ua_hold_r;
    fh_cmd.arm_time = now_r + NOW_W'(delay_q_r);
    ua_cmd.arm_time = now_r;
    case (op_r)
      OP_FH_REQ: fh_cmd.req = 1'b1;
      OP_FH_REL: fh_cmd.rel = 1'b1;
      OP_UA_REQ: ua_cmd.req = 1'b1;
      OP_UA_REL: ua_cmd.rel = 1'b1;
      OP_SENSE:  fh_cmd.arm = sens_arm;
      OP_TICK: begin
        fh_cmd.tick = 1'b1;
        ua_cmd.tick = 1'b1;
      end
      default: ;
    endcase
  end

  dsft_chan u_fh (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (proc),
    .cmd      (fh_cmd),
    .stat     (fh_stat),
    .stat_nxt (fh_nxt),
    .fire     (fh_fire)
  );

  dsft_chan u_ua (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (proc),
    .cmd      (ua_cmd),
    .stat     (ua_stat),
    .stat_nxt (ua_nxt),
    .fire     (ua_fire)
  );

  always_comb begin
    if (fh_fire || ua_fire) begin
      tone_nxt = TONE_FIRE;
    end else if (sens_arm) begin
      tone_nxt = TONE_OK;
    end else begin
      tone_nxt = TONE_NONE;
    end
  end

  // Result register
  chan_stat_t fh_out_r, ua_out_r;
  tone_t      tone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      fh_out_r <= fh_nxt;
      ua_out_r <= ua_nxt;
      tone_r   <= tone_nxt;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.forehand_drive   = fh_out_r.pin;
  assign out_if.underarm_drive   = ua_out_r.pin;
  assign out_if.forehand_pending = fh_out_r.order;
  assign out_if.underarm_pending = ua_out_r.order;
  assign out_if.forehand_when    = fh_out_r.order_time;
  assign out_if.underarm_when    = ua_out_r.order_time;
  assign out_if.tone             = tone_r;

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(op_r) && $stable(now_r)))
    else $error("stalled input item lost");

  a_proc_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_valid_r)
    else $error("processed item missing from result register");

  // The result just taken matches the channel state it left behind.
  a_result_is_state: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (fh_out_r == fh_stat && ua_out_r == ua_stat))
    else $error("result register out of step with channel state");

  a_fire_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tone_r == TONE_FIRE) |-> (fh_out_r.pin || ua_out_r.pin))
    else $error("fire tone without a driven pin");

  a_ok_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tone_r == TONE_OK) |-> fh_out_r.order)
    else $error("success tone without a forehand order");

endmodule

// ===== design/dsft_chan.sv =====
// One actuator channel: order flag, order time and pin level.
module dsft_chan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  dsft_pkg::chan_cmd_t   cmd,
  output dsft_pkg::chan_stat_t  stat,
  output dsft_pkg::chan_stat_t  stat_nxt,
  output logic                  fire
);
  import dsft_pkg::*;

  logic             order_r, order_nxt;
  logic [NOW_W-1:0] when_r, when_nxt;
  logic             pin_r, pin_nxt;
  logic [NOW_W-1:0] rel_limit;
  logic [NOW_W-1:0] hold_limit;
  logic             due;

  assign rel_limit  = when_r + RELEASE_GUARD;
  assign hold_limit = when_r + NOW_W'(cmd.hold);
  assign due        = cmd.now >= when_r;

  always_comb begin
    order_nxt = order_r;
    when_nxt  = when_r;
    pin_nxt   = pin_r;
    fire      = 1'b0;
    if (cmd.req) begin
      // Re-arm only when idle or when the new time is earlier.
      if (!order_r || cmd.now < when_r) begin
        order_nxt = 1'b1;
        when_nxt  = cmd.now;
      end
    end else if (cmd.rel) begin
      if (cmd.now > rel_limit) begin
        order_nxt = 1'b0;
      end
    end else if (cmd.arm) begin
      order_nxt = 1'b1;
      when_nxt  = cmd.arm_time;
    end else if (cmd.tick) begin
      if (order_r && due) begin
        pin_nxt = 1'b1;
        fire    = 1'b1;
      end else if (!order_r && cmd.now > hold_limit) begin
        pin_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
      when_r  <= '0;
      pin_r   <= 1'b0;
    end else if (en) begin
      order_r <= order_nxt;
      when_r  <= when_nxt;
      pin_r   <= pin_nxt;
    end
  end

  assign stat     = '{pin: pin_r, order: order_r, order_time: when_r};
  assign stat_nxt = '{pin: pin_nxt, order: order_nxt, order_time: when_nxt};

  // A fire needs a pending order that is due.
  a_fire_needs_order: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (order_r && due && cmd.tick))
    else $error("fire without a due order");

  a_fire_sets_pin: assert property (@(posedge clk) disable iff (!rst_n)
    (en && fire) |=> pin_r)
    else $error("pin not set after fire");

  a_arm_sets_order: assert property (@(posedge clk) disable iff (!rst_n)
    (en && cmd.arm) |=> (order_r && when_r == $past(cmd.arm_time)))
    else $error("sensor arm lost");

endmodule
